// File: rtl/core/pwsa_pkg.sv
// Shared types and constants for the perspective warp source address block.
`default_nettype none
package pwsa_pkg;

  localparam int unsigned CoefW = 48;
  localparam int unsigned PerspW = 32;
  localparam int unsigned CoordW = 11;
  // Numerator width: two 48x12 products plus a 48-bit term.
  localparam int unsigned NumW = 62;
  // Denominator width: two 32x12 products plus a 56-bit term.
  localparam int unsigned DenW = 58;
  localparam int unsigned DefImageWidth = 2048;
  localparam int unsigned DefImageHeight = 2048;

  typedef enum logic [2:0] {
    REG_M00  = 3'd0,
    REG_M01  = 3'd1,
    REG_M02  = 3'd2,
    REG_M10  = 3'd3,
    REG_M11  = 3'd4,
    REG_M12  = 3'd5,
    REG_PERSP = 3'd6,
    REG_M22  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CoefW-1:0]  m00;
    logic [CoefW-1:0]  m01;
    logic [CoefW-1:0]  m02;
    logic [CoefW-1:0]  m10;
    logic [CoefW-1:0]  m11;
    logic [CoefW-1:0]  m12;
    logic [PerspW-1:0] px;
    logic [PerspW-1:0] py;
    logic [CoefW-1:0]  m22;
  } coef_t;

  // Per-request control carried down the divider row.
  typedef struct packed {
    logic vld;
    logic ok;
    logic negx;
    logic negy;
  } ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/perspective_warp_source_address.sv
// Pipeline: front end, a row of QB division cells, result register; QB = clog2(max(width, height)).
// Throughput: one request per cycle.
// The rate is set by the row of QB division cells, one quotient bit per cell,
// which advances as a whole; it stalls only while a result waits on m_axis.
// Reset: matrix registers return to identity, the pipeline empties; no clearing pass.
`default_nettype none
module perspective_warp_source_address #(
  parameter int unsigned IMAGE_WIDTH = pwsa_pkg::DefImageWidth,
  parameter int unsigned IMAGE_HEIGHT = pwsa_pkg::DefImageHeight
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // [10:0] dst_x, [21:11] dst_y, [23:22] zero
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [10:0] src_x, [21:11] src_y, [23:22] zero
  output logic        m_axis_tuser,   // [0] inside_res
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [63:0] cfg_data_i
);
  localparam int unsigned MaxDim = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int unsigned QB = $clog2(MaxDim);
  localparam int unsigned DW = pwsa_pkg::DenW;
  localparam int unsigned CW = pwsa_pkg::CoordW;

  pwsa_pkg::coef_t coef_q;
  logic            adv;

  pwsa_pkg::ctl_t  ctl [QB+1];
  logic [DW-1:0]   b   [QB+1];
  logic [DW-1:0]   rx  [QB+1];
  logic [DW-1:0]   ry  [QB+1];
  logic [QB-1:0]   bx  [QB+1];
  logic [QB-1:0]   by  [QB+1];
  logic [QB-1:0]   qx  [QB+1];
  logic [QB-1:0]   qy  [QB+1];

  logic [CW-1:0]   src_x, src_y;
  logic            in_img;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{m00: 48'h0001_0000_0000, m11: 48'h0001_0000_0000,
                  m22: 48'h0001_0000_0000, default: '0};
    end else if (cfg_valid_i) begin
      case (pwsa_pkg::cfg_reg_e'(cfg_index_i))
        pwsa_pkg::REG_M00:   coef_q.m00 <= cfg_data_i[47:0];
        pwsa_pkg::REG_M01:   coef_q.m01 <= cfg_data_i[47:0];
        pwsa_pkg::REG_M02:   coef_q.m02 <= cfg_data_i[47:0];
        pwsa_pkg::REG_M10:   coef_q.m10 <= cfg_data_i[47:0];
        pwsa_pkg::REG_M11:   coef_q.m11 <= cfg_data_i[47:0];
        pwsa_pkg::REG_M12:   coef_q.m12 <= cfg_data_i[47:0];
        pwsa_pkg::REG_PERSP: begin
          coef_q.px <= cfg_data_i[31:0];
          coef_q.py <= cfg_data_i[63:32];
        end
        pwsa_pkg::REG_M22:   coef_q.m22 <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  pwsa_front #(.QB(QB)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .in_vld_i (s_axis_tvalid),
    .x_i      (s_axis_tdata[10:0]),
    .y_i      (s_axis_tdata[21:11]),
    .coef_i   (coef_q),
    .ctl_o    (ctl[0]),
    .b_o      (b[0]),
    .rem_x_o  (rx[0]),
    .rem_y_o  (ry[0]),
    .bits_x_o (bx[0]),
    .bits_y_o (by[0])
  );

  assign qx[0] = '0;
  assign qy[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    pwsa_cell #(.QB(QB)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .ctl_i    (ctl[k]),
      .b_i      (b[k]),
      .rem_x_i  (rx[k]),
      .rem_y_i  (ry[k]),
      .bits_x_i (bx[k]),
      .bits_y_i (by[k]),
      .q_x_i    (qx[k]),
      .q_y_i    (qy[k]),
      .ctl_o    (ctl[k+1]),
      .b_o      (b[k+1]),
      .rem_x_o  (rx[k+1]),
      .rem_y_o  (ry[k+1]),
      .bits_x_o (bx[k+1]),
      .bits_y_o (by[k+1]),
      .q_x_o    (qx[k+1]),
      .q_y_o    (qy[k+1])
    );
  end

  pwsa_round #(
    .QB           (QB),
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .ctl_i    (ctl[QB]),
    .b_i      (b[QB]),
    .rem_x_i  (rx[QB]),
    .rem_y_i  (ry[QB]),
    .q_x_i    (qx[QB]),
    .q_y_i    (qy[QB]),
    .vld_o    (m_axis_tvalid),
    .src_x_o  (src_x),
    .src_y_o  (src_y),
    .inside_o (in_img)
  );

  assign m_axis_tdata = {2'b00, src_y, src_x};
  assign m_axis_tuser = in_img;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !in_img |-> (src_x == '0) && (src_y == '0))
    else $error("outside result with nonzero coordinates");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && in_img |-> (32'(src_x) < IMAGE_WIDTH) && (32'(src_y) < IMAGE_HEIGHT))
    else $error("inside result beyond image bounds");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i == pwsa_pkg::REG_M00) |=> coef_q.m00 == $past(cfg_data_i[47:0]))
    else $error("coefficient write lost");

endmodule
`default_nettype wire

// File: rtl/core/pwsa_front.sv
// Front end: matrix products, sums, magnitudes and divider seed.
`default_nettype none
module pwsa_front #(
  parameter int unsigned QB = 11
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           adv_i,
  input  wire                           in_vld_i,
  input  wire [pwsa_pkg::CoordW-1:0]    x_i,
  input  wire [pwsa_pkg::CoordW-1:0]    y_i,
  input  wire pwsa_pkg::coef_t          coef_i,
  output pwsa_pkg::ctl_t                ctl_o,
  output logic [pwsa_pkg::DenW-1:0]     b_o,
  output logic [pwsa_pkg::DenW-1:0]     rem_x_o,
  output logic [pwsa_pkg::DenW-1:0]     rem_y_o,
  output logic [QB-1:0]                 bits_x_o,
  output logic [QB-1:0]                 bits_y_o
);
  localparam int unsigned NW = pwsa_pkg::NumW;
  localparam int unsigned DW = pwsa_pkg::DenW;
  localparam int unsigned PW = pwsa_pkg::CoefW + 12;
  localparam int unsigned QW = pwsa_pkg::PerspW + 12;
  localparam int unsigned AW = NW + 8;
  localparam int unsigned TW = AW - QB;

  // stage 1: products
  logic                 v1_q;
  logic signed [PW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic signed [QW-1:0] p20_q, p21_q;
  logic signed [11:0]   xs, ys;
  // stage 2: sums
  logic                 v2_q;
  logic signed [NW-1:0] nx_q, ny_q;
  logic signed [DW-1:0] d_q;
  // stage 3: magnitudes
  logic                 v3_q, dz_q, negx_q, negy_q;
  logic [NW-1:0]        ax_q, ay_q;
  logic [DW-1:0]        b3_q;
  // stage 4 seed
  logic [AW-1:0]        ax_sh, ay_sh;
  logic                 bigx, bigy;
  pwsa_pkg::ctl_t       ctl_q;

  assign xs = $signed({1'b0, x_i});
  assign ys = $signed({1'b0, y_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      ctl_q <= '0;
    end else if (adv_i) begin
      v1_q  <= in_vld_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      ctl_q <= '{vld: v3_q, ok: !dz_q && !bigx && !bigy, negx: negx_q, negy: negy_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p00_q <= $signed(coef_i.m00) * xs;
      p01_q <= $signed(coef_i.m01) * ys;
      p10_q <= $signed(coef_i.m10) * xs;
      p11_q <= $signed(coef_i.m11) * ys;
      p20_q <= $signed(coef_i.px) * xs;
      p21_q <= $signed(coef_i.py) * ys;
      nx_q  <= NW'(p00_q) + NW'(p01_q) + NW'($signed(coef_i.m02));
      ny_q  <= NW'(p10_q) + NW'(p11_q) + NW'($signed(coef_i.m12));
      d_q   <= DW'(p20_q) + DW'(p21_q) + (DW'($signed(coef_i.m22)) <<< 8);
      dz_q   <= (d_q == '0);
      negx_q <= nx_q[NW-1] ^ d_q[DW-1];
      negy_q <= ny_q[NW-1] ^ d_q[DW-1];
      ax_q   <= nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
      ay_q   <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
      b3_q   <= d_q[DW-1] ? DW'(-d_q) : DW'(d_q);
      b_o      <= b3_q;
      rem_x_o  <= DW'(ax_sh[AW-1:QB]);
      rem_y_o  <= DW'(ay_sh[AW-1:QB]);
      bits_x_o <= ax_sh[QB-1:0];
      bits_y_o <= ay_sh[QB-1:0];
    end
  end

  // Quotient of 2^QB or more is off the image in any case.
  assign ax_sh = {ax_q, 8'd0};
  assign ay_sh = {ay_q, 8'd0};
  assign bigx  = ax_sh[AW-1:QB] >= TW'(b3_q);
  assign bigy  = ay_sh[AW-1:QB] >= TW'(b3_q);
  assign ctl_o = ctl_q;

endmodule
`default_nettype wire

// File: rtl/core/pwsa_cell.sv
// One restoring-division cell: one quotient bit for each of the two lanes.
`default_nettype none
module pwsa_cell #(
  parameter int unsigned QB = 11
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        adv_i,
  input  wire pwsa_pkg::ctl_t        ctl_i,
  input  wire [pwsa_pkg::DenW-1:0]   b_i,
  input  wire [pwsa_pkg::DenW-1:0]   rem_x_i,
  input  wire [pwsa_pkg::DenW-1:0]   rem_y_i,
  input  wire [QB-1:0]               bits_x_i,
  input  wire [QB-1:0]               bits_y_i,
  input  wire [QB-1:0]               q_x_i,
  input  wire [QB-1:0]               q_y_i,
  output pwsa_pkg::ctl_t             ctl_o,
  output logic [pwsa_pkg::DenW-1:0]  b_o,
  output logic [pwsa_pkg::DenW-1:0]  rem_x_o,
  output logic [pwsa_pkg::DenW-1:0]  rem_y_o,
  output logic [QB-1:0]              bits_x_o,
  output logic [QB-1:0]              bits_y_o,
  output logic [QB-1:0]              q_x_o,
  output logic [QB-1:0]              q_y_o
);
  localparam int unsigned DW = pwsa_pkg::DenW;

  logic [DW:0]    rx, ry, bz;
  logic           gex, gey;
  pwsa_pkg::ctl_t ctl_q;

  assign bz  = {1'b0, b_i};
  assign rx  = {rem_x_i, bits_x_i[QB-1]};
  assign ry  = {rem_y_i, bits_y_i[QB-1]};
  assign gex = rx >= bz;
  assign gey = ry >= bz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_o      <= b_i;
      rem_x_o  <= gex ? DW'(rx - bz) : rx[DW-1:0];
      rem_y_o  <= gey ? DW'(ry - bz) : ry[DW-1:0];
      bits_x_o <= bits_x_i << 1;
      bits_y_o <= bits_y_i << 1;
      q_x_o    <= (q_x_i << 1) | QB'(gex);
      q_y_o    <= (q_y_i << 1) | QB'(gey);
    end
  end

  assign ctl_o = ctl_q;

  // Partial remainder stays below the divisor on a live request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.vld && ctl_q.ok |-> (rem_x_o < b_o) && (rem_y_o < b_o))
    else $error("pwsa_cell: remainder not below divisor");

endmodule
`default_nettype wire

// File: rtl/core/pwsa_round.sv
// Round to nearest even, range check and result register.
`default_nettype none
module pwsa_round #(
  parameter int unsigned QB = 11,
  parameter int unsigned IMAGE_WIDTH = pwsa_pkg::DefImageWidth,
  parameter int unsigned IMAGE_HEIGHT = pwsa_pkg::DefImageHeight
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           adv_i,
  input  wire pwsa_pkg::ctl_t           ctl_i,
  input  wire [pwsa_pkg::DenW-1:0]      b_i,
  input  wire [pwsa_pkg::DenW-1:0]      rem_x_i,
  input  wire [pwsa_pkg::DenW-1:0]      rem_y_i,
  input  wire [QB-1:0]                  q_x_i,
  input  wire [QB-1:0]                  q_y_i,
  output logic                          vld_o,
  output logic [pwsa_pkg::CoordW-1:0]   src_x_o,
  output logic [pwsa_pkg::CoordW-1:0]   src_y_o,
  output logic                          inside_o
);
  localparam int unsigned DW = pwsa_pkg::DenW;
  localparam logic [QB:0] WLim = (QB+1)'(IMAGE_WIDTH);
  localparam logic [QB:0] HLim = (QB+1)'(IMAGE_HEIGHT);

  logic [DW:0] tx, ty, bz;
  logic        upx, upy, ok;
  logic [QB:0] qx, qy;

  assign bz  = {1'b0, b_i};
  assign tx  = {rem_x_i, 1'b0};
  assign ty  = {rem_y_i, 1'b0};
  assign upx = (tx > bz) || ((tx == bz) && q_x_i[0]);
  assign upy = (ty > bz) || ((ty == bz) && q_y_i[0]);
  assign qx  = (QB+1)'(q_x_i) + (QB+1)'(upx);
  assign qy  = (QB+1)'(q_y_i) + (QB+1)'(upy);
  // a negative quotient that rounds to zero is still on the image
  assign ok  = ctl_i.ok && !(ctl_i.negx && (qx != '0)) && !(ctl_i.negy && (qy != '0))
               && (qx < WLim) && (qy < HLim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (adv_i) begin
      vld_o <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      src_x_o  <= ok ? pwsa_pkg::CoordW'(qx) : '0;
      src_y_o  <= ok ? pwsa_pkg::CoordW'(qy) : '0;
      inside_o <= ok;
    end
  end

endmodule
`default_nettype wire

// File: verif/tb.sv
// Testbench for the perspective warp source address block: self-checking against
// an exact fixed point predictor.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned ImgW = 2048;
  localparam int unsigned ImgH = 2048;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned Drain = 40;
  localparam logic [63:0] One = 64'h1_0000_0000;

  typedef struct packed {
    logic [pwsa_pkg::CoordW-1:0] sx;
    logic [pwsa_pkg::CoordW-1:0] sy;
    logic                        in_img;
  } src_addr_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  logic [63:0] matrix [8];
  src_addr_t   addr_q [$];
  int          errors = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  perspective_warp_source_address dut (.*);

  initial forever #5 clk_i = ~clk_i;

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Exact num*2^8/den, rounded half to even; clears ok on overflow, a negative result or one beyond limit - 1.
  function automatic logic [pwsa_pkg::CoordW-1:0] round_quot(input longint num,
                                                             input longint den,
                                                             input int unsigned limit,
                                                             inout bit ok);
    logic [127:0] an, b, q, r, twice;
    bit neg;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? 128'(-num) : 128'(num);
    b = (den < 0) ? 128'(-den) : 128'(den);
    an = an << 8;
    q = an / b;
    r = an % b;
    if (q >= (128'd1 << 30)) begin
      ok = 1'b0;
      return '0;
    end
    twice = r << 1;
    if (twice > b || (twice == b && q[0])) q++;
    if (neg && q != 0) begin
      ok = 1'b0;
      return '0;
    end
    if (q > limit - 1) ok = 1'b0;
    return q[pwsa_pkg::CoordW-1:0];
  endfunction

  function automatic src_addr_t map_pixel(input logic [10:0] dx, input logic [10:0] dy);
    longint x, y, nx, ny, d;
    bit ok;
    src_addr_t a;
    x = dx;
    y = dy;
    nx = $signed(matrix[pwsa_pkg::REG_M00][47:0]) * x
         + $signed(matrix[pwsa_pkg::REG_M01][47:0]) * y
         + $signed(matrix[pwsa_pkg::REG_M02][47:0]);
    ny = $signed(matrix[pwsa_pkg::REG_M10][47:0]) * x
         + $signed(matrix[pwsa_pkg::REG_M11][47:0]) * y
         + $signed(matrix[pwsa_pkg::REG_M12][47:0]);
    d = longint'($signed(matrix[pwsa_pkg::REG_PERSP][31:0])) * x
        + longint'($signed(matrix[pwsa_pkg::REG_PERSP][63:32])) * y
        + longint'($signed(matrix[pwsa_pkg::REG_M22][47:0])) * 256;
    ok = 1'b1;
    a = '0;
    if (d == 0) ok = 1'b0;
    else begin
      a.sx = round_quot(nx, d, ImgW, ok);
      a.sy = round_quot(ny, d, ImgH, ok);
    end
    if (!ok) begin
      a.sx = '0;
      a.sy = '0;
    end
    a.in_img = ok;
    return a;
  endfunction

  task automatic write_reg(input pwsa_pkg::cfg_reg_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    matrix[idx] = (idx == pwsa_pkg::REG_PERSP) ? val : {16'd0, val[47:0]};
    @(posedge clk_i);
  endtask

  task automatic load_matrix(input logic [63:0] m [8]);
    for (int i = 0; i < 8; i++) write_reg(pwsa_pkg::cfg_reg_e'(i), m[i]);
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [10:0] dx, input logic [10:0] dy);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, dy, dx};
    do @(posedge clk_i); while (!s_axis_tready);
    addr_q.push_back(map_pixel(dx, dy));
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random();
    send_pixel(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
  endtask

  // Waits for the pipeline to empty before touching registers.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (addr_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd_coef(input longint lo, input longint hi);
    longint v;
    v = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
    return 64'(v);
  endfunction

  // Plausible warp: scale near 1, shear, shift, light perspective.
  task automatic random_warp();
    logic [63:0] m [8];
    logic [63:0] px, py;
    px = rnd_coef(-(2**26), 2**26);
    py = rnd_coef(-(2**26), 2**26);
    m[pwsa_pkg::REG_M00] = rnd_coef(longint'(1) << 31, (longint'(5) << 32) / 2);
    m[pwsa_pkg::REG_M01] = rnd_coef(-(2**30), 2**30);
    m[pwsa_pkg::REG_M02] = rnd_coef(-(longint'(300) << 32), longint'(300) << 32);
    m[pwsa_pkg::REG_M10] = rnd_coef(-(2**30), 2**30);
    m[pwsa_pkg::REG_M11] = rnd_coef(longint'(1) << 31, (longint'(5) << 32) / 2);
    m[pwsa_pkg::REG_M12] = rnd_coef(-(longint'(300) << 32), longint'(300) << 32);
    m[pwsa_pkg::REG_PERSP] = {py[31:0], px[31:0]};
    m[pwsa_pkg::REG_M22] = rnd_coef(longint'(1) << 31, longint'(1) << 33);
    load_matrix(m);
  endtask

  task automatic test_identity();
    logic [63:0] m [8];
    m = '{One, 0, 0, 0, One, 0, 0, One};
    load_matrix(m);
    send_pixel(0, 0);
    send_pixel(11'h7FF, 11'h7FF);
    send_pixel(11'h555, 11'h2AA);
    send_pixel(11'h2AA, 11'h555);
    settle();
  endtask

  task automatic test_special();
    logic [63:0] m [8];
    // half pixel shift in x gives ties; quarter pixel back in y gives negative zero
    m = '{One, 0, 64'h8000_0000, 0, One, -64'sh4000_0000, 0, One};
    load_matrix(m);
    send_pixel(0, 0);
    send_pixel(1, 1);
    send_pixel(2, 2);
    send_pixel(11'h7FE, 5);
    send_pixel(11'h7FF, 5);
    settle();
    // zero denominator
    m = '{One, 0, 0, 0, One, 0, 0, 0};
    load_matrix(m);
    send_pixel(3, 4);
    send_pixel(0, 0);
    settle();
    // negative mapping and register extremes
    m = '{-64'sd1 << 32, 0, 0, 0, One, 0, 0, One};
    load_matrix(m);
    send_pixel(5, 5);
    send_pixel(0, 7);
    settle();
    m = '{64'h7FFF_FFFF_FFFF, 64'h8000_0000_0000, 64'h7FFF_FFFF_FFFF,
          64'h8000_0000_0000, 64'h7FFF_FFFF_FFFF, 64'h8000_0000_0000,
          64'h8000_0000_7FFF_FFFF, 64'h7FFF_FFFF_FFFF};
    load_matrix(m);
    send_pixel(0, 0);
    send_pixel(11'h7FF, 11'h7FF);
    send_pixel(11'h7FF, 0);
    m = '{64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0,
          64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000};
    settle();
    load_matrix(m);
    send_pixel(11'h7FF, 11'h7FF);
    send_pixel(1, 0);
    settle();
  endtask

  task automatic test_random_warps();
    for (int p = 0; p < 7; p++) begin
      random_warp();
      repeat (80) send_random();
      settle();
    end
    // raw register noise
    for (int i = 0; i < 8; i++) write_reg(pwsa_pkg::cfg_reg_e'(i), {$urandom, $urandom});
    repeat (40) send_random();
    settle();
  endtask

  task automatic test_backpressure();
    random_warp();
    hold_req = 1'b1;
    repeat (60) send_random();
    hold_req = 1'b0;
    settle();
  endtask

  task automatic test_full_rate();
    calm = 1'b1;
    random_warp();
    repeat (150) send_random();
    settle();
  endtask

  // result acceptor: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (100) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        wait (!hold_req);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (addr_q.size() == 0) report("unexpected result", 0, 0);
      else begin
        src_addr_t want;
        want = addr_q.pop_front();
        if (m_axis_tdata[10:0] != want.sx) report("src_x", m_axis_tdata[10:0], want.sx);
        if (m_axis_tdata[21:11] != want.sy) report("src_y", m_axis_tdata[21:11], want.sy);
        if (m_axis_tuser != want.in_img) report("inside_res", m_axis_tuser, want.in_img);
      end
    end
  end

  initial begin
    matrix = '{One, 0, 0, 0, One, 0, 0, One};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset state is identity
    send_pixel(17, 1000);
    settle();
    test_identity();
    test_special();
    test_random_warps();
    test_backpressure();
    test_full_rate();
    if (errors == 0 && addr_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: perspective_warp_source_address.f
rtl/core/pwsa_pkg.sv
rtl/core/pwsa_front.sv
rtl/core/pwsa_cell.sv
rtl/core/pwsa_round.sv
rtl/core/perspective_warp_source_address.sv
verif/tb.sv
